// ----- hw/rtl/szpd_pkg.sv -----
// ----------------------------------------------------------------------------
// szpd_pkg
// Shared constants for the smoothed z-score peak detector: configuration
// register indexes, reset values and peak codes.
// ----------------------------------------------------------------------------
`default_nettype none

package szpd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LAG       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INFLUENCE = 2'd2;

  // register widths and reset values
  localparam int LAG_W = 6;
  localparam int Q_W   = 16;

  localparam logic [LAG_W-1:0] LAG_RESET  = 6'd30;
  localparam logic [Q_W-1:0]   THR_RESET  = 16'd20480;
  localparam logic [Q_W-1:0]   INFL_RESET = 16'd0;

  // influence of one in Q1.15
  localparam logic [Q_W:0] INFL_ONE = 17'd32768;

  // samples-seen counter saturates here
  localparam int          SEEN_W   = 7;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 7'd127;

  // peak signal codes (2-bit signed)
  localparam logic [1:0] PEAK_NONE = 2'b00;
  localparam logic [1:0] PEAK_POS  = 2'b01;
  localparam logic [1:0] PEAK_NEG  = 2'b11;

endpackage

`default_nettype wire

// ----- hw/rtl/szpd_ram.sv -----
// ----------------------------------------------------------------------------
// szpd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module szpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/smoothed_zscore_peak_detector_core.sv -----
// ----------------------------------------------------------------------------
// smoothed_zscore_peak_detector_core
// Smoothed z-score peak detector: flags samples far from the running window
// mean, blends flagged samples into the filtered window, and recomputes
// window mean and sample deviation with one shared multiplier and a
// bit-serial divider / square-root unit.
// ----------------------------------------------------------------------------
// Throughput: one word at a time; in_stall stays high until the result is
//   loaded. The window walk, the two serial division passes and the square root set the rate.
// Reset: synchronous active-low; clears control, pointers and statistics only.
`default_nettype none

module smoothed_zscore_peak_detector_core #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input words
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_sample,
  // result words
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic signed [1:0]                    out_peak_signal,
  output      logic signed [SAMPLE_BITS-1:0]        out_filtered_value,
  output      logic signed [SAMPLE_BITS-1:0]        out_window_mean,
  output      logic [SAMPLE_BITS-1:0]               out_window_std,
  output      logic                                 out_warming_up,
  // configuration writes
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [szpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [szpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // widths
  localparam int SB   = SAMPLE_BITS;
  localparam int NW   = $clog2(MAX_WINDOW);
  localparam int NCW  = NW + 1;
  localparam int SUMW = SB + NW + 1;
  localparam int SQSW = 2 * SB + NW;
  localparam int NSQW = SQSW + NCW;
  localparam int DW   = NSQW;
  localparam int SQW  = DW + (DW % 2);
  localparam int RW   = SQW / 2;
  localparam int SRW  = RW + 3;
  localparam int DENW = 2 * NCW;
  localparam int PW   = (SUMW + 1 > 18) ? SUMW + 1 : 18;
  localparam int MW   = 2 * PW;
  localparam int CW   = $clog2(SQW + 1);
  localparam int LXW  = (NCW > 6) ? NCW : 6;
  localparam int CMPW = MW + 13;
  localparam int SEW  = szpd_pkg::SEEN_W;

  localparam logic signed [MW-1:0] SMP_HI = MW'((longint'(1) <<< (SB - 1)) - longint'(1));
  localparam logic signed [MW-1:0] SMP_LO = -SMP_HI - MW'(1);
  localparam logic [RW:0]          STD_MAX = (RW + 1)'({SB{1'b1}});

  // sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_TEST   = 5'd1;
  localparam logic [4:0] ST_CMP    = 5'd2;
  localparam logic [4:0] ST_BL1    = 5'd3;
  localparam logic [4:0] ST_BL2    = 5'd4;
  localparam logic [4:0] ST_BL3    = 5'd5;
  localparam logic [4:0] ST_WRITE  = 5'd6;
  localparam logic [4:0] ST_ACC    = 5'd7;
  localparam logic [4:0] ST_NMUL   = 5'd8;
  localparam logic [4:0] ST_DEN    = 5'd9;
  localparam logic [4:0] ST_SQ     = 5'd10;
  localparam logic [4:0] ST_SPREAD = 5'd11;
  localparam logic [4:0] ST_DIVV   = 5'd12;
  localparam logic [4:0] ST_SQRT   = 5'd13;
  localparam logic [4:0] ST_RND    = 5'd14;
  localparam logic [4:0] ST_DIVM   = 5'd15;
  localparam logic [4:0] ST_DONE   = 5'd16;

  function automatic logic signed [SB-1:0] sat_smp(input logic signed [MW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SMP_HI) begin
      r = SB'(SMP_HI);
    end else if (v < SMP_LO) begin
      r = SB'(SMP_LO);
    end else begin
      r = SB'(v);
    end
    return r;
  endfunction

  // registers
  logic [4:0]                      state_r, state_nxt;
  logic [szpd_pkg::LAG_W-1:0]      lag_r, lag_nxt;
  logic [szpd_pkg::Q_W-1:0]        thr_r, thr_nxt;
  logic [szpd_pkg::Q_W-1:0]        infl_r, infl_nxt;
  logic [NW-1:0]                   wp_r, wp_nxt;
  logic [SEW-1:0]                  seen_r, seen_nxt;
  logic signed [SB-1:0]            prev_f_r, prev_f_nxt;
  logic signed [SB-1:0]            prev_mean_r, prev_mean_nxt;
  logic [SB-1:0]                   prev_std_r, prev_std_nxt;
  logic signed [SB-1:0]            y_r, y_nxt;
  logic signed [SB-1:0]            f_r, f_nxt;
  logic [1:0]                      sig_r, sig_nxt;
  logic                            warm_path_r, warm_path_nxt;
  logic                            warm_out_r, warm_out_nxt;
  logic [NCW-1:0]                  n_r, n_nxt;
  logic [NCW-1:0]                  issue_r, issue_nxt;
  logic [NW-1:0]                   rd_addr_r, rd_addr_nxt;
  logic                            rd_v_r, rd_v_nxt;
  logic                            sq_v_r, sq_v_nxt;
  logic signed [SUMW-1:0]          sum_r, sum_nxt;
  logic [SQSW-1:0]                 sumsq_r, sumsq_nxt;
  logic [NSQW-1:0]                 nsq_r, nsq_nxt;
  logic [NSQW-1:0]                 mcand_r, mcand_nxt;
  logic [CW-1:0]                   k_r, k_nxt;
  logic [DENW-1:0]                 den_r, den_nxt;
  logic [DW-1:0]                   quo_r, quo_nxt;
  logic [DENW:0]                   rem_r, rem_nxt;
  logic [SQW-1:0]                  rad_r, rad_nxt;
  logic [RW-1:0]                   root_r, root_nxt;
  logic [SRW-1:0]                  srem_r, srem_nxt;
  logic                            mneg_r, mneg_nxt;
  logic signed [SB-1:0]            mean_r, mean_nxt;
  logic [SB-1:0]                   std_r, std_nxt;
  logic signed [MW-1:0]            acc_r, acc_nxt;
  logic signed [MW-1:0]            prod_r, prod_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      o_sig_r, o_sig_nxt;
  logic signed [SB-1:0]            o_f_r, o_f_nxt;
  logic signed [SB-1:0]            o_mean_r, o_mean_nxt;
  logic [SB-1:0]                   o_std_r, o_std_nxt;
  logic                            o_warm_r, o_warm_nxt;

  // combinational helpers
  logic signed [PW-1:0]            mul_a, mul_b;
  logic [LXW-1:0]                  lag_x, lag_eff;
  logic [szpd_pkg::Q_W:0]          infl_eff;
  logic                            in_acc;
  logic                            ram_we, ram_re;
  logic [SB-1:0]                   ram_rdata;
  logic signed [SB:0]              diff;
  logic [SB:0]                     adiff;
  logic [CMPW-1:0]                 cmp_lhs, cmp_rhs;
  logic [DENW:0]                   div_sh;
  logic                            div_bit;
  logic [SRW-1:0]                  sq_sh, sq_trial;
  logic [RW:0]                     root_rnd;
  logic signed [SUMW+1:0]          mean_a;
  logic [DENW-1:0]                 den2;
  logic signed [MW-1:0]            mean_v;
  logic [SEW-1:0]                  seen_inc;

  // effective configuration
  always_comb begin
    lag_x = LXW'(lag_r);
    if (lag_x < LXW'(2)) begin
      lag_eff = LXW'(2);
    end else if (lag_x > LXW'(MAX_WINDOW - 1)) begin
      lag_eff = LXW'(MAX_WINDOW - 1);
    end else begin
      lag_eff = lag_x;
    end
    infl_eff = (17'(infl_r) > szpd_pkg::INFL_ONE) ? szpd_pkg::INFL_ONE : 17'(infl_r);
  end

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // window memory
  assign ram_we = (state_r == ST_WRITE);
  assign ram_re = (state_r == ST_ACC) && (issue_r < n_r);

  szpd_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (f_r),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_TEST: begin
        mul_a = PW'(thr_r);
        mul_b = PW'(prev_std_r);
      end
      ST_BL1: begin
        mul_a = PW'(infl_eff);
        mul_b = PW'(y_r);
      end
      ST_BL2: begin
        mul_a = PW'(szpd_pkg::INFL_ONE - infl_eff);
        mul_b = PW'(prev_f_r);
      end
      ST_ACC: begin
        mul_a = PW'(signed'(ram_rdata));
        mul_b = PW'(signed'(ram_rdata));
      end
      ST_DEN: begin
        mul_a = PW'(n_r);
        mul_b = PW'(n_r - NCW'(1));
      end
      ST_SQ: begin
        mul_a = PW'(sum_r);
        mul_b = PW'(sum_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // datapath helpers
  always_comb begin
    diff     = (SB + 1)'(y_r) - (SB + 1)'(prev_mean_r);
    adiff    = diff[SB] ? unsigned'(-diff) : unsigned'(diff);
    cmp_lhs  = CMPW'(adiff) << 12;
    cmp_rhs  = CMPW'(unsigned'(prod_r));
    div_sh   = {rem_r[DENW-1:0], quo_r[DW-1]};
    div_bit  = (div_sh >= {1'b0, den_r});
    sq_sh    = {srem_r[SRW-3:0], rad_r[SQW-1:SQW-2]};
    sq_trial = SRW'({root_r, 2'b01});
    root_rnd = (RW + 1)'(root_r) + (((srem_r > SRW'(root_r))) ? (RW + 1)'(1) : '0);
    mean_a   = signed'({sum_r[SUMW-1], sum_r, 1'b0}) + signed'((SUMW + 2)'(n_r));
    den2     = DENW'({n_r, 1'b0});
    seen_inc = seen_r + SEW'(1);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    lag_nxt       = lag_r;
    thr_nxt       = thr_r;
    infl_nxt      = infl_r;
    wp_nxt        = wp_r;
    seen_nxt      = seen_r;
    prev_f_nxt    = prev_f_r;
    prev_mean_nxt = prev_mean_r;
    prev_std_nxt  = prev_std_r;
    y_nxt         = y_r;
    f_nxt         = f_r;
    sig_nxt       = sig_r;
    warm_path_nxt = warm_path_r;
    warm_out_nxt  = warm_out_r;
    n_nxt         = n_r;
    issue_nxt     = issue_r;
    rd_addr_nxt   = rd_addr_r;
    rd_v_nxt      = 1'b0;
    sq_v_nxt      = 1'b0;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    nsq_nxt       = nsq_r;
    mcand_nxt     = mcand_r;
    k_nxt         = k_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    mneg_nxt      = mneg_r;
    mean_nxt      = mean_r;
    std_nxt       = std_r;
    acc_nxt       = acc_r;
    mean_v        = '0;
    out_valid_nxt = out_valid_r && out_stall;
    o_sig_nxt     = o_sig_r;
    o_f_nxt       = o_f_r;
    o_mean_nxt    = o_mean_r;
    o_std_nxt     = o_std_r;
    o_warm_nxt    = o_warm_r;

    // configuration writes
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        szpd_pkg::REG_LAG:       lag_nxt  = cfg_data[szpd_pkg::LAG_W-1:0];
        szpd_pkg::REG_THRESHOLD: thr_nxt  = cfg_data;
        szpd_pkg::REG_INFLUENCE: infl_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          y_nxt         = in_sample;
          sig_nxt       = szpd_pkg::PEAK_NONE;
          warm_path_nxt = (LXW + 1)'(seen_r) < (LXW + 1)'(lag_eff);
          if ((LXW + 1)'(seen_r) < (LXW + 1)'(lag_eff)) begin
            f_nxt     = in_sample;
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_TEST;
          end
        end
      end
      // threshold * previous deviation
      ST_TEST: state_nxt = ST_CMP;
      ST_CMP: begin
        if (cmp_lhs > cmp_rhs) begin
          sig_nxt   = (diff > 0) ? szpd_pkg::PEAK_POS : szpd_pkg::PEAK_NEG;
          state_nxt = ST_BL1;
        end else begin
          f_nxt     = y_r;
          state_nxt = ST_WRITE;
        end
      end
      // blend: infl*y + (1-infl)*prev, rounded
      ST_BL1: state_nxt = ST_BL2;
      ST_BL2: begin
        acc_nxt   = prod_r + MW'(16384);
        state_nxt = ST_BL3;
      end
      ST_BL3: begin
        f_nxt     = sat_smp((acc_r + prod_r) >>> 15);
        state_nxt = ST_WRITE;
      end
      // store filtered value, decide on statistics
      ST_WRITE: begin
        prev_f_nxt  = f_r;
        wp_nxt      = (wp_r == NW'(MAX_WINDOW - 1)) ? '0 : wp_r + NW'(1);
        rd_addr_nxt = wp_r;
        issue_nxt   = '0;
        sum_nxt     = '0;
        sumsq_nxt   = '0;
        if (seen_r < szpd_pkg::SEEN_MAX) begin
          seen_nxt = seen_inc;
        end
        if (warm_path_r) begin
          warm_out_nxt = (LXW + 1)'(seen_inc) < (LXW + 1)'(lag_eff);
          n_nxt        = NCW'(lag_eff);
          if ((LXW + 1)'(seen_inc) < (LXW + 1)'(lag_eff)) begin
            mean_nxt  = '0;
            std_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_ACC;
          end
        end else begin
          warm_out_nxt = 1'b0;
          n_nxt        = NCW'(lag_eff + LXW'(1));
          state_nxt    = ST_ACC;
        end
      end
      // walk the window newest first: read, square, accumulate
      ST_ACC: begin
        if (issue_r < n_r) begin
          rd_v_nxt    = 1'b1;
          issue_nxt   = issue_r + NCW'(1);
          rd_addr_nxt = (rd_addr_r == '0) ? NW'(MAX_WINDOW - 1) : rd_addr_r - NW'(1);
        end
        sq_v_nxt = rd_v_r;
        if (rd_v_r) begin
          sum_nxt = sum_r + SUMW'(signed'(ram_rdata));
        end
        if (sq_v_r) begin
          sumsq_nxt = sumsq_r + prod_r[SQSW-1:0];
        end
        if ((issue_r == n_r) && !rd_v_r && !sq_v_r) begin
          nsq_nxt   = '0;
          mcand_nxt = NSQW'(sumsq_r);
          quo_nxt   = DW'(n_r);
          k_nxt     = '0;
          state_nxt = ST_NMUL;
        end
      end
      // n * sumsq by shift and add
      ST_NMUL: begin
        if (quo_r[0]) begin
          nsq_nxt = nsq_r + mcand_r;
        end
        mcand_nxt = mcand_r << 1;
        quo_nxt   = quo_r >> 1;
        k_nxt     = k_r + CW'(1);
        if (k_r == CW'(NCW - 1)) begin
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: state_nxt = ST_SQ;
      ST_SQ: begin
        den_nxt   = prod_r[DENW-1:0];
        state_nxt = ST_SPREAD;
      end
      ST_SPREAD: begin
        quo_nxt   = nsq_r - prod_r[NSQW-1:0];
        rem_nxt   = '0;
        k_nxt     = '0;
        state_nxt = ST_DIVV;
      end
      // restoring division, one quotient bit per cycle
      ST_DIVV, ST_DIVM: begin
        rem_nxt = div_bit ? (div_sh - {1'b0, den_r}) : div_sh;
        quo_nxt = {quo_r[DW-2:0], div_bit};
        k_nxt   = k_r + CW'(1);
        if (k_r == CW'(DW - 1)) begin
          k_nxt = '0;
          if (state_r == ST_DIVV) begin
            rad_nxt   = SQW'({quo_r[DW-2:0], div_bit});
            root_nxt  = '0;
            srem_nxt  = '0;
            state_nxt = ST_SQRT;
          end else begin
            mean_v        = signed'(MW'({quo_r[DW-2:0], div_bit}));
            mean_v        = mneg_r ? -mean_v : mean_v;
            mean_nxt      = sat_smp(mean_v);
            prev_mean_nxt = sat_smp(mean_v);
            prev_std_nxt  = std_r;
            state_nxt     = ST_DONE;
          end
        end
      end
      // square root, one result bit per cycle
      ST_SQRT: begin
        rad_nxt = rad_r << 2;
        if (sq_sh >= sq_trial) begin
          srem_nxt = sq_sh - sq_trial;
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          srem_nxt = sq_sh;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        k_nxt = k_r + CW'(1);
        if (k_r == CW'(RW - 1)) begin
          state_nxt = ST_RND;
        end
      end
      // round the root, set up the mean division
      ST_RND: begin
        std_nxt  = (root_rnd > STD_MAX) ? SB'(STD_MAX) : SB'(root_rnd);
        mneg_nxt = mean_a[SUMW+1];
        den_nxt  = den2;
        rem_nxt  = '0;
        k_nxt    = '0;
        if (mean_a[SUMW+1]) begin
          quo_nxt = DW'(unsigned'(-mean_a)) + DW'(den2) - DW'(1);
        end else begin
          quo_nxt = DW'(unsigned'(mean_a));
        end
        state_nxt = ST_DIVM;
      end
      // load the result word
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_sig_nxt     = sig_r;
          o_f_nxt       = f_r;
          o_mean_nxt    = mean_r;
          o_std_nxt     = std_r;
          o_warm_nxt    = warm_out_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lag_r       <= szpd_pkg::LAG_RESET;
      thr_r       <= szpd_pkg::THR_RESET;
      infl_r      <= szpd_pkg::INFL_RESET;
      wp_r        <= '0;
      seen_r      <= '0;
      prev_f_r    <= '0;
      prev_mean_r <= '0;
      prev_std_r  <= '0;
      rd_v_r      <= 1'b0;
      sq_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lag_r       <= lag_nxt;
      thr_r       <= thr_nxt;
      infl_r      <= infl_nxt;
      wp_r        <= wp_nxt;
      seen_r      <= seen_nxt;
      prev_f_r    <= prev_f_nxt;
      prev_mean_r <= prev_mean_nxt;
      prev_std_r  <= prev_std_nxt;
      rd_v_r      <= rd_v_nxt;
      sq_v_r      <= sq_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    y_r         <= y_nxt;
    f_r         <= f_nxt;
    sig_r       <= sig_nxt;
    warm_path_r <= warm_path_nxt;
    warm_out_r  <= warm_out_nxt;
    n_r         <= n_nxt;
    issue_r     <= issue_nxt;
    rd_addr_r   <= rd_addr_nxt;
    sum_r       <= sum_nxt;
    sumsq_r     <= sumsq_nxt;
    nsq_r       <= nsq_nxt;
    mcand_r     <= mcand_nxt;
    k_r         <= k_nxt;
    den_r       <= den_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    rad_r       <= rad_nxt;
    root_r      <= root_nxt;
    srem_r      <= srem_nxt;
    mneg_r      <= mneg_nxt;
    mean_r      <= mean_nxt;
    std_r       <= std_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    o_sig_r     <= o_sig_nxt;
    o_f_r       <= o_f_nxt;
    o_mean_r    <= o_mean_nxt;
    o_std_r     <= o_std_nxt;
    o_warm_r    <= o_warm_nxt;
  end

  // outputs
  assign out_valid          = out_valid_r;
  assign out_peak_signal    = signed'(o_sig_r);
  assign out_filtered_value = o_f_r;
  assign out_window_mean    = o_mean_r;
  assign out_window_std     = o_std_r;
  assign out_warming_up     = o_warm_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a word");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> issue_r <= n_r)
    else $error("window read count ran past window length");

  a_warm_no_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_warming_up |-> out_peak_signal == signed'(szpd_pkg::PEAK_NONE))
    else $error("peak flagged during warm-up");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && (!out_valid_r || !out_stall) |=> out_valid_r && state_r == ST_IDLE)
    else $error("result word not loaded");

endmodule

`default_nettype wire

// ----- tb/tb_smoothed_zscore_peak_detector_core.sv -----
// ----------------------------------------------------------------------------
// tb_smoothed_zscore_peak_detector_core
// Self-checking bench for the smoothed z-score peak detector. A clocked
// driver sends sample words from a queue, a clocked monitor predicts every
// accepted word with an in-bench copy of the detector and checks each result
// word field by field. Runs directed corner words, then random phases with
// varied window, threshold and influence settings and random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_smoothed_zscore_peak_detector_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 64;
  localparam int SB  = 16;

  // index with no register behind it
  localparam logic [szpd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]           peak;
    logic signed [SB-1:0] filt;
    logic signed [SB-1:0] mean;
    logic [SB-1:0]        std;
    logic                 warm;
  } peak_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [1:0] out_peak_signal;
  logic signed [SB-1:0] out_filtered_value, out_window_mean;
  logic [SB-1:0] out_window_std;
  logic out_warming_up;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [szpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [szpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  smoothed_zscore_peak_detector_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_peak_signal(out_peak_signal), .out_filtered_value(out_filtered_value),
    .out_window_mean(out_window_mean), .out_window_std(out_window_std),
    .out_warming_up(out_warming_up),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shared bench state
  logic signed [SB-1:0] sample_queue[$];
  peak_result_t         expected_results[$];
  int  errors = 0;
  int  words_checked = 0;
  int  peaks_seen = 0;
  bit  no_idle = 1'b0;
  bit  long_hold_req = 1'b0;

  // predictor state
  longint fwin[WIN];
  int     wr_ptr;
  int     seen_cnt;
  longint prev_filt, prev_mean, prev_std;
  int     lag_reg, thr_reg, infl_reg;

  function automatic longint div_floor(longint a, longint b);
    if (a >= 0) return a / b;
    return -((-a + b - 1) / b);
  endfunction

  function automatic longint clamp_sample(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned root_nearest(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    if (v - r * r > r) r++;
    return r;
  endfunction

  // mean and sample deviation over the n newest window entries
  function automatic void window_stats(input int n, output longint m, output longint s);
    longint sum, x;
    longint unsigned sumsq, s2, spread, r;
    int idx;
    sum = 0;
    sumsq = 0;
    for (int k = 0; k < n; k++) begin
      idx = (wr_ptr + WIN - 1 - k) % WIN;
      x = fwin[idx];
      sum += x;
      sumsq += longint'(x * x);
    end
    m = clamp_sample(div_floor(2 * sum + n, 2 * n));
    s2 = (sum < 0) ? -sum : sum;
    spread = longint'(n) * sumsq - s2 * s2;
    r = root_nearest(spread / (longint'(n) * longint'(n - 1)));
    s = (r > 65535) ? 65535 : r;
  endfunction

  function automatic peak_result_t detect_peak(logic signed [SB-1:0] smp);
    peak_result_t res;
    longint y, f, m, s, d, ad;
    int lag, infl;
    bit warm;
    y = smp;
    m = 0;
    s = 0;
    lag = (lag_reg < 2) ? 2 : ((lag_reg > WIN - 1) ? WIN - 1 : lag_reg);
    infl = (infl_reg > 32768) ? 32768 : infl_reg;
    res.peak = szpd_pkg::PEAK_NONE;
    if (seen_cnt < lag) begin
      f = y;
      fwin[wr_ptr] = f;
      wr_ptr = (wr_ptr + 1) % WIN;
      seen_cnt++;
      warm = seen_cnt < lag;
      if (!warm) begin
        window_stats(lag, m, s);
        prev_mean = m;
        prev_std = s;
      end
    end else begin
      d = y - prev_mean;
      ad = (d < 0) ? -d : d;
      if (ad * 4096 > longint'(thr_reg) * prev_std) begin
        res.peak = (d > 0) ? szpd_pkg::PEAK_POS : szpd_pkg::PEAK_NEG;
        f = clamp_sample(div_floor(longint'(infl) * y
            + longint'(32768 - infl) * prev_filt + 16384, 32768));
      end else begin
        f = y;
      end
      fwin[wr_ptr] = f;
      wr_ptr = (wr_ptr + 1) % WIN;
      if (seen_cnt < 127) seen_cnt++;
      window_stats(lag + 1, m, s);
      prev_mean = m;
      prev_std = s;
      warm = 1'b0;
    end
    prev_filt = f;
    res.filt = f[SB-1:0];
    res.mean = m[SB-1:0];
    res.std  = s[SB-1:0];
    res.warm = warm;
    return res;
  endfunction

  // sender: one word per queue entry, random gap after each
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && in_stall) begin
      // hold the stalled word
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (sample_queue.size() > 0) begin
      in_sample <= sample_queue.pop_front();
      in_valid <= 1'b1;
      send_gap <= no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stall per word, plus one long hold-off on request
  int stall_left = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 600;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= (hold_cnt > 1);
    end else if (out_valid && !out_stall) begin
      stall_left <= no_idle ? 0 : $urandom_range(0, 11);
      out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 1) == 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: track config, predict accepted words, check result words
  always @(posedge clk) begin
    peak_result_t want;
    if (!rst_n) begin
      wr_ptr = 0;
      seen_cnt = 0;
      prev_filt = 0;
      prev_mean = 0;
      prev_std = 0;
      lag_reg = szpd_pkg::LAG_RESET;
      thr_reg = szpd_pkg::THR_RESET;
      infl_reg = szpd_pkg::INFL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          szpd_pkg::REG_LAG:       lag_reg = cfg_data[szpd_pkg::LAG_W-1:0];
          szpd_pkg::REG_THRESHOLD: thr_reg = cfg_data;
          szpd_pkg::REG_INFLUENCE: infl_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_results.push_back(detect_peak(in_sample));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          words_checked++;
          if (want.peak != szpd_pkg::PEAK_NONE) peaks_seen++;
          if (out_peak_signal !== want.peak) begin
            $error("peak_signal exp %0d got %0d", $signed(want.peak), out_peak_signal);
            errors++;
          end
          if (out_filtered_value !== want.filt) begin
            $error("filtered_value exp %0d got %0d", want.filt, out_filtered_value);
            errors++;
          end
          if (out_window_mean !== want.mean) begin
            $error("window_mean exp %0d got %0d", want.mean, out_window_mean);
            errors++;
          end
          if (out_window_std !== want.std) begin
            $error("window_std exp %0d got %0d", want.std, out_window_std);
            errors++;
          end
          if (out_warming_up !== want.warm) begin
            $error("warming_up exp %0d got %0d", want.warm, out_warming_up);
            errors++;
          end
        end
      end
    end
  end

  task automatic cfg_write(input logic [szpd_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[szpd_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait for all results, then let the block settle
  task automatic wait_drained();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (300) @(posedge clk);
  endtask

  // noisy baseline with occasional spikes; a few full-range words
  task automatic queue_series(input int count);
    int base, amp;
    base = (int'($urandom_range(0, 65535)) - 32768) / 2;
    amp = $urandom_range(1, 2000);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        sample_queue.push_back(SB'($urandom_range(0, 65535)));
      else if ($urandom_range(0, 11) == 0)
        sample_queue.push_back(SB'(clamp_sample(base + (($urandom_range(0, 1) == 1) ? 1 : -1)
                               * int'($urandom_range(amp * 4, 30000)))));
      else
        sample_queue.push_back(SB'(clamp_sample(base + int'($urandom_range(0, 2 * amp))
                               - amp)));
    end
  endtask

  int phase_words = 0;

  // stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // lag below range, zero threshold, influence above one
    cfg_write(szpd_pkg::REG_LAG, 0);
    cfg_write(szpd_pkg::REG_THRESHOLD, 0);
    cfg_write(szpd_pkg::REG_INFLUENCE, 65535);
    cfg_write(REG_UNUSED, 16'h1234);
    sample_queue = '{32767, -32768, 0, 1, -1, 32767, -32768, 32767, 0, -32768, 5, 5};
    wait_drained();

    // lag one, max threshold, half influence
    cfg_write(szpd_pkg::REG_LAG, 1);
    cfg_write(szpd_pkg::REG_THRESHOLD, 65535);
    cfg_write(szpd_pkg::REG_INFLUENCE, 16384);
    sample_queue = '{100, -100, 32767, -32768, 100, 7};
    wait_drained();

    // widest window, influence one, so flagged words pass unfiltered
    cfg_write(szpd_pkg::REG_LAG, 63);
    cfg_write(szpd_pkg::REG_THRESHOLD, 4096);
    cfg_write(szpd_pkg::REG_INFLUENCE, 32768);
    queue_series(80);
    phase_words = 98;
    wait_drained();

    // random phases; samples seen are past any lag, so a lag change does not re-enter warm-up
    for (int p = 0; phase_words < 1700; p++) begin
      case ($urandom_range(0, 7))
        0: cfg_write(szpd_pkg::REG_LAG, $urandom_range(0, 1));
        1: cfg_write(szpd_pkg::REG_LAG, $urandom_range(32, 63));
        default: cfg_write(szpd_pkg::REG_LAG, $urandom_range(2, 12));
      endcase
      cfg_write(szpd_pkg::REG_THRESHOLD, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(2048, 16384));
      cfg_write(szpd_pkg::REG_INFLUENCE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 32768));
      if ($urandom_range(0, 4) == 0) cfg_write(REG_UNUSED, $urandom_range(0, 65535));
      no_idle = (p % 4 == 3);
      if (p == 2) long_hold_req = 1'b1;
      queue_series(120);
      phase_words += 120;
      wait_drained();
    end

    $display("Checked %0d result words (%0d flagged peaks) over %0d sample words,",
             words_checked, peaks_seen, phase_words);
    $display("covering warm-up, window limits, saturation and stall patterns.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- smoothed_zscore_peak_detector_core.f -----
hw/rtl/szpd_pkg.sv
hw/rtl/szpd_ram.sv
hw/rtl/smoothed_zscore_peak_detector_core.sv
tb/tb_smoothed_zscore_peak_detector_core.sv
